/* sv/usd_pkg.sv */
// Shared types, codes and constants of the tar stream deframer.
`default_nettype none
package usd_pkg;

   localparam int BLOCK_BYTES      = 512;
   localparam int SIZE_FIELD_CHARS = 12;
   localparam int SIZE_BITS        = 36;

   localparam logic [8:0] BLOCK_LAST = 9'(BLOCK_BYTES - 1);
   localparam logic [8:0] SIZE_FIRST = 9'd124;
   localparam logic [8:0] SIZE_END   = 9'(124 + SIZE_FIELD_CHARS);
   localparam logic [8:0] TYPE_OFS   = 9'd156;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_DIR   = 8'h35;

   localparam logic [2:0] ROLE_HEADER  = 3'd0;
   localparam logic [2:0] ROLE_DATA    = 3'd1;
   localparam logic [2:0] ROLE_SKIP    = 3'd2;
   localparam logic [2:0] ROLE_PAD     = 3'd3;
   localparam logic [2:0] ROLE_IGNORED = 3'd4;

   localparam logic [1:0] KIND_FILE  = 2'd0;
   localparam logic [1:0] KIND_DIR   = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SIZE  = 2'd1;
   localparam logic [1:0] STATUS_TRUNC = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_BODY   = 3'd1,
      PH_PAD    = 3'd2,
      PH_END    = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] value;
      logic                 digit_seen;
      logic                 bad;
   } size_state_type;

   typedef struct packed {
      logic [7:0]           byte_value;
      logic [2:0]           byte_role;
      logic                 entry_valid;
      logic [1:0]           entry_kind;
      logic [7:0]           entry_type_char;
      logic [SIZE_BITS-1:0] entry_size;
      logic                 data_last;
      logic                 archive_end;
      logic [1:0]           status;
      logic [15:0]          entries_seen;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/usd_req_if.sv */
// Input channel carrying one archive word per handshake.
`default_nettype none
interface usd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] archive_byte;
   logic       final_byte;

   modport source (output valid, output archive_byte, output final_byte, input ready);
   modport sink (input valid, input archive_byte, input final_byte, output ready);
endinterface
`default_nettype wire

/* sv/usd_rsp_if.sv */
// Result channel carrying one tagged word per handshake.
`default_nettype none
interface usd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic [2:0]  byte_role;
   logic        entry_valid;
   logic [1:0]  entry_kind;
   logic [7:0]  entry_type_char;
   logic [35:0] entry_size;
   logic        data_last;
   logic        archive_end;
   logic [1:0]  status;
   logic [15:0] entries_seen;

   modport source (output valid, output byte_value, output byte_role, output entry_valid,
                   output entry_kind, output entry_type_char, output entry_size,
                   output data_last, output archive_end, output status,
                   output entries_seen, input ready);
   modport sink (input valid, input byte_value, input byte_role, input entry_valid,
                 input entry_kind, input entry_type_char, input entry_size,
                 input data_last, input archive_end, input status,
                 input entries_seen, output ready);
endinterface
`default_nettype wire

/* sv/usd_size_parse.sv */
// Octal size field parser with shift-add accumulator.
`default_nettype none
module usd_size_parse (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  load,
   input  wire logic [7:0]            char_in,
   output usd_pkg::size_state_type    size_out
);

   logic [usd_pkg::SIZE_BITS-1:0] acc_ff, acc_in;
   logic                          digit_ff, digit_in;
   logic                          done_ff, done_in;
   logic                          bad_ff, bad_in;

   always_comb begin
      acc_in   = acc_ff;
      digit_in = digit_ff;
      done_in  = done_ff;
      bad_in   = bad_ff;
      priority if (clear) begin
         acc_in   = '0;
         digit_in = 1'b0;
         done_in  = 1'b0;
         bad_in   = 1'b0;
      end else if (load && !done_ff) begin
         priority if (char_in == usd_pkg::CHAR_NUL || char_in == usd_pkg::CHAR_SPACE) begin
            if (digit_ff) begin
               done_in = 1'b1;
            end
         end else if (char_in < usd_pkg::CHAR_ZERO || char_in > usd_pkg::CHAR_SEVEN) begin
            bad_in  = 1'b1;
            done_in = 1'b1;
         end else if (acc_ff[usd_pkg::SIZE_BITS-1:usd_pkg::SIZE_BITS-3] != 3'd0) begin
            bad_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            acc_in   = {acc_ff[usd_pkg::SIZE_BITS-4:0], char_in[2:0]};
            digit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         digit_ff <= 1'b0;
         done_ff  <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         digit_ff <= digit_in;
         done_ff  <= done_in;
         bad_ff   <= bad_in;
      end
   end

   assign size_out.value      = acc_ff;
   assign size_out.digit_seen = digit_ff;
   assign size_out.bad        = bad_ff;

endmodule
`default_nettype wire

/* sv/ustar_stream_deframer_core.sv */
// Top level of the tar stream deframer: input register, block parser, result register.
//
//   channel  | direction | contents
//   req_ch   | in        | archive_byte, final_byte
//   rsp_ch   | out       | tagged word with entry, end and status fields
//   csr_*    | in        | extract_enable write
//
// One word enters per cycle unless rsp_ch stalls, and its result is registered.
// The parse state updates as a word moves from the input register to the result register.
// A stalled result register holds the input register, and input stalls once both are full.
// Synchronous reset clears all control and parse state; extract mode resets to listing.
`default_nettype none
module ustar_stream_deframer_core #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   usd_req_if.sink    req_ch,
   usd_rsp_if.source  rsp_ch,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data
);

   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    in_byte_ff;
   logic                          in_final_ff;
   logic                          out_valid_ff, out_valid_in;
   usd_pkg::rsp_type              out_ff, rsp_in;
   logic                          extract_ff;
   logic                          advance;
   logic                          req_take;

   usd_pkg::phase_type            phase_ff, phase_in;
   logic [8:0]                    offset_ff, offset_in;
   logic                          all_zero_ff, all_zero_in;
   logic [1:0]                    run_ff, run_in;
   logic [7:0]                    type_ff, type_in;
   logic [usd_pkg::SIZE_BITS-1:0] body_ff, body_in, body_dec;
   logic [8:0]                    pad_ff, pad_in;
   logic                          is_file_ff, is_file_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [1:0]                    err_ff, err_in;
   logic [31:0]                   count_wide;

   logic                          size_clear, size_load;
   usd_pkg::size_state_type       size_cur;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   usd_size_parse u_size (
      .clock    (clock),
      .reset    (reset),
      .clear    (size_clear && advance),
      .load     (size_load && advance),
      .char_in  (in_byte_ff),
      .size_out (size_cur)
   );

   assign body_dec   = body_ff - usd_pkg::SIZE_BITS'(body_ff != '0);
   assign count_wide = 32'(count_in);

   always_comb begin
      logic                          fin;
      logic [7:0]                    tf;
      logic [1:0]                    kind;
      phase_in    = phase_ff;
      offset_in   = offset_ff;
      all_zero_in = all_zero_ff;
      run_in      = run_ff;
      type_in     = type_ff;
      body_in     = body_ff;
      pad_in      = pad_ff;
      is_file_in  = is_file_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      size_clear  = 1'b0;
      size_load   = 1'b0;
      fin         = in_final_ff;
      tf          = (type_ff == usd_pkg::CHAR_NUL) ? usd_pkg::CHAR_ZERO : type_ff;
      kind        = (tf == usd_pkg::CHAR_ZERO) ? usd_pkg::KIND_FILE :
                    (tf == usd_pkg::CHAR_DIR) ? usd_pkg::KIND_DIR : usd_pkg::KIND_OTHER;
      rsp_in      = '0;
      rsp_in.byte_value = in_byte_ff;
      rsp_in.byte_role  = usd_pkg::ROLE_IGNORED;
      unique case (phase_ff)
         usd_pkg::PH_HEADER: begin
            rsp_in.byte_role = usd_pkg::ROLE_HEADER;
            if (in_byte_ff != usd_pkg::CHAR_NUL) begin
               all_zero_in = 1'b0;
            end
            size_load = (offset_ff >= usd_pkg::SIZE_FIRST) && (offset_ff < usd_pkg::SIZE_END);
            if (offset_ff == usd_pkg::TYPE_OFS) begin
               type_in = in_byte_ff;
            end
            if (offset_ff == usd_pkg::BLOCK_LAST) begin
               offset_in  = '0;
               size_clear = 1'b1;
               type_in    = usd_pkg::CHAR_NUL;
               priority if (all_zero_in) begin
                  run_in = run_ff + 2'd1;
                  if (run_in >= 2'd2) begin
                     rsp_in.archive_end = 1'b1;
                     phase_in = usd_pkg::PH_END;
                  end
               end else if (size_cur.bad || !size_cur.digit_seen) begin
                  run_in   = 2'd0;
                  err_in   = usd_pkg::STATUS_SIZE;
                  phase_in = usd_pkg::PH_ERROR;
               end else begin
                  run_in = 2'd0;
                  rsp_in.entry_valid     = 1'b1;
                  rsp_in.entry_type_char = tf;
                  rsp_in.entry_size      = size_cur.value;
                  rsp_in.entry_kind      = kind;
                  if (kind != usd_pkg::KIND_OTHER && count_ff != '1) begin
                     count_in = count_ff + COUNT_BITS'(1);
                  end
                  if (kind != usd_pkg::KIND_DIR && size_cur.value != '0) begin
                     body_in    = size_cur.value;
                     pad_in     = 9'd0 - size_cur.value[8:0];
                     is_file_in = (kind == usd_pkg::KIND_FILE);
                     phase_in   = usd_pkg::PH_BODY;
                  end
               end
               all_zero_in = 1'b1;
            end else begin
               offset_in = offset_ff + 9'd1;
            end
         end
         usd_pkg::PH_BODY: begin
            rsp_in.byte_role = (is_file_ff && extract_ff) ? usd_pkg::ROLE_DATA
                                                          : usd_pkg::ROLE_SKIP;
            body_in = body_dec;
            if (body_dec == '0) begin
               rsp_in.data_last = is_file_ff;
               phase_in = (pad_ff != '0) ? usd_pkg::PH_PAD : usd_pkg::PH_HEADER;
            end
         end
         usd_pkg::PH_PAD: begin
            rsp_in.byte_role = usd_pkg::ROLE_PAD;
            pad_in = pad_ff - 9'(pad_ff != '0);
            if (pad_in == '0) begin
               phase_in = usd_pkg::PH_HEADER;
            end
         end
         default: begin
            fin = 1'b0;
         end
      endcase
      if (fin && phase_in != usd_pkg::PH_END && phase_in != usd_pkg::PH_ERROR) begin
         err_in   = usd_pkg::STATUS_TRUNC;
         phase_in = usd_pkg::PH_ERROR;
      end
      rsp_in.status       = err_in;
      rsp_in.entries_seen = count_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= usd_pkg::PH_HEADER;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         extract_ff   <= 1'b0;
         offset_ff    <= '0;
         all_zero_ff  <= 1'b1;
         run_ff       <= '0;
         type_ff      <= '0;
         body_ff      <= '0;
         pad_ff       <= '0;
         is_file_ff   <= 1'b0;
         count_ff     <= '0;
         err_ff       <= usd_pkg::STATUS_OK;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            extract_ff <= csr_write_data;
         end
         if (advance) begin
            offset_ff   <= offset_in;
            all_zero_ff <= all_zero_in;
            run_ff      <= run_in;
            type_ff     <= type_in;
            body_ff     <= body_in;
            pad_ff      <= pad_in;
            is_file_ff  <= is_file_in;
            count_ff    <= count_in;
            err_ff      <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_ch.archive_byte;
         in_final_ff <= req_ch.final_byte;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.byte_value      = out_ff.byte_value;
   assign rsp_ch.byte_role       = out_ff.byte_role;
   assign rsp_ch.entry_valid     = out_ff.entry_valid;
   assign rsp_ch.entry_kind      = out_ff.entry_kind;
   assign rsp_ch.entry_type_char = out_ff.entry_type_char;
   assign rsp_ch.entry_size      = out_ff.entry_size;
   assign rsp_ch.data_last       = out_ff.data_last;
   assign rsp_ch.archive_end     = out_ff.archive_end;
   assign rsp_ch.status          = out_ff.status;
   assign rsp_ch.entries_seen    = out_ff.entries_seen;

   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == usd_pkg::PH_END) |=> (phase_ff == usd_pkg::PH_END))
      else $error("end phase left without reset");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == usd_pkg::PH_ERROR) |=> (phase_ff == usd_pkg::PH_ERROR) && $stable(err_ff))
      else $error("error phase or status changed without reset");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_final_ff)))
      else $error("stalled input word was lost or changed");

   a_data_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.byte_role == usd_pkg::ROLE_DATA) |-> (extract_ff && is_file_ff))
      else $error("data word delivered outside extract mode");

endmodule
`default_nettype wire
